/* hw/rtl/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2
  } phase_t;

  // Result word kinds
  typedef enum logic [1:0] {
    K_BYTE = 2'd0,
    K_DONE = 2'd1,
    K_ERR  = 2'd2
  } kind_t;

  // Error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_NOQUOTE = 3'd1;
  localparam logic [2:0] E_CTRL    = 3'd2;
  localparam logic [2:0] E_UNTERM  = 3'd3;
  localparam logic [2:0] E_ESC     = 3'd4;
  localparam logic [2:0] E_NUL     = 3'd5;
  localparam logic [2:0] E_FULL    = 3'd6;

  // Characters of interest
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5c;
  localparam logic [7:0] CHR_SLASH  = 8'h2f;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  // Register map
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [15:0] CAP_RESET = 16'd64;

  // One result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  dbyte;
    logic [15:0] length;
    logic [2:0]  err;
  } result_t;

  // Escape letter to decoded byte; top bit set when the escape is known
  function automatic logic [8:0] esc_map(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      CHR_QUOTE:  r = {1'b1, CHR_QUOTE};
      CHR_BSLASH: r = {1'b1, CHR_BSLASH};
      CHR_SLASH:  r = {1'b1, CHR_SLASH};
      8'h62:      r = {1'b1, 8'd8};   // b
      8'h66:      r = {1'b1, 8'd12};  // f
      8'h6e:      r = {1'b1, 8'd10};  // n
      8'h72:      r = {1'b1, 8'd13};  // r
      8'h74:      r = {1'b1, 8'd9};   // t
      default:    r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/jsu_decode.sv */
`timescale 1ns / 1ps

// Next-state and result logic for one byte of the string
module jsu_decode (
  input  jsu_pkg::phase_t  phase,
  input  logic [15:0]      count,
  input  logic [15:0]      capacity,
  input  logic [7:0]       byte_in,
  input  logic             line_end,
  output logic             emit,
  output jsu_pkg::result_t res,
  output jsu_pkg::phase_t  phase_nxt,
  output logic [15:0]      count_nxt
);
  import jsu_pkg::*;

  logic       store_en;
  logic [7:0] store_c;
  logic [8:0] esc;
  logic [16:0] count_inc;

  assign esc       = esc_map(byte_in);
  assign count_inc = {1'b0, count} + 17'd1;

  always_comb begin
    emit      = 1'b0;
    res       = '0;
    phase_nxt = phase;
    count_nxt = count;
    store_en  = 1'b0;
    store_c   = byte_in;

    case (phase)
      PH_IDLE: begin
        if (line_end || byte_in != CHR_QUOTE) begin
          emit     = 1'b1;
          res.kind = K_ERR;
          res.err  = E_NOQUOTE;
        end else begin
          count_nxt = '0;
          phase_nxt = PH_STR;
        end
      end
      PH_ESC: begin
        if (line_end) begin
          emit      = 1'b1;
          res.kind  = K_ERR;
          res.err   = E_UNTERM;
          phase_nxt = PH_IDLE;
        end else if (!esc[8]) begin
          emit      = 1'b1;
          res.kind  = K_ERR;
          res.err   = E_ESC;
          phase_nxt = PH_IDLE;
        end else begin
          store_en = 1'b1;
          store_c  = esc[7:0];
        end
      end
      default: begin
        // inside the string
        if (line_end) begin
          emit      = 1'b1;
          res.kind  = K_ERR;
          res.err   = E_UNTERM;
          phase_nxt = PH_IDLE;
        end else if (byte_in == CHR_QUOTE) begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
          if (count >= capacity) begin
            res.kind = K_ERR;
            res.err  = E_FULL;
          end else begin
            res.kind   = K_DONE;
            res.length = count;
          end
        end else if (byte_in < CTRL_LIMIT) begin
          emit      = 1'b1;
          res.kind  = K_ERR;
          res.err   = E_CTRL;
          phase_nxt = PH_IDLE;
        end else if (byte_in == CHR_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          store_en = 1'b1;
        end
      end
    endcase

    // Store one decoded byte, checking NUL and buffer room
    if (store_en) begin
      emit = 1'b1;
      if (store_c == 8'd0) begin
        res.kind  = K_ERR;
        res.err   = E_NUL;
        phase_nxt = PH_IDLE;
      end else if (count_inc >= {1'b0, capacity}) begin
        res.kind  = K_ERR;
        res.err   = E_FULL;
        phase_nxt = PH_IDLE;
      end else begin
        res.kind  = K_BYTE;
        res.dbyte = store_c;
        count_nxt = count_inc[15:0];
        phase_nxt = PH_STR;
      end
    end
  end

endmodule

/* hw/rtl/jsu_out_reg.sv */
`timescale 1ns / 1ps

// Result register towards the master side
module jsu_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  jsu_pkg::result_t res_in,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output jsu_pkg::result_t res_out
);
  import jsu_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

endmodule

/* hw/rtl/json_string_unescape_unit.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/tready     tdata: byte_req, tlast: line_end
// out_      out  out_tvalid/tready    tdata: decoded_byte, length, error_code; tuser: kind
// cfg_      in   APB, pready high     capacity at byte address 0
//
// One word per cycle sustained while out_tready stays high. A word is held in the input register
// and is decoded into the result register once that register has room, so its result
// is registered and waits there until the master takes it.
// The registered phase/count update bounds the rate.
// Reset (synchronous, rst_n low) empties both registers, sets idle and capacity 64.
// A stalled master holds the result register; the input register then fills and
// in_tready drops.
module json_string_unescape_unit (
  input  logic        clk,
  input  logic        rst_n,
  // slave side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_req
  input  logic        in_tlast,   // line_end
  // master side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] decoded_byte, [23:8] length, [26:24] error_code
  output logic [1:0]  out_tuser,  // [1:0] kind
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import jsu_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_end_r;
  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [15:0] count_r;
  logic [15:0] count_nxt;
  logic [15:0] capacity_r;
  logic        slot_free;
  logic        advance;
  logic        emit;
  result_t     res;
  result_t     res_out;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? {16'd0, capacity_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_CAPACITY) begin
      capacity_r <= cfg_pwdata[15:0];
    end
  end

  // Input register
  assign advance   = s1_valid_r && slot_free;
  assign in_tready = !s1_valid_r || slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  jsu_decode u_decode (
    .phase     (phase_r),
    .count     (count_r),
    .capacity  (capacity_r),
    .byte_in   (s1_byte_r),
    .line_end  (s1_end_r),
    .emit      (emit),
    .res       (res),
    .phase_nxt (phase_nxt),
    .count_nxt (count_nxt)
  );

  jsu_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && emit),
    .res_in    (res),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_out)
  );

  // Pack the result word
  assign out_tdata = {5'd0, res_out.err, res_out.length, res_out.dbyte};
  assign out_tuser = res_out.kind;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import jsu_pkg::*;

  localparam int         IDLE_LIMIT    = 4000;
  localparam int         SETTLE_CYCLES = 4;
  localparam logic [2:0] CAP_ADDR      = {REG_CAPACITY, 2'b00};

  // Escape letters accepted after a backslash
  localparam logic [7:0] ESC_LETTERS [8] = '{CHR_QUOTE, CHR_BSLASH, CHR_SLASH,
                                              "b", "f", "n", "r", "t"};

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] byte_req
  logic        in_tlast    = 1'b0; // line_end
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [7:0] decoded_byte, [23:8] length, [26:24] error_code
  logic [1:0]  out_tuser;          // [1:0] kind
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  json_string_unescape_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder prediction and result comparison
  class unescape_scoreboard;
    phase_t      phase;
    logic [15:0] count;
    logic [15:0] capacity;
    result_t     expected_q[$];
    int          mismatches;

    function new();
      phase      = PH_IDLE;
      count      = '0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [15:0] v);
      capacity = v;
    endfunction

    function void push_result(kind_t k, logic [7:0] d, logic [15:0] len, logic [2:0] e);
      result_t r;
      r.kind   = k;
      r.dbyte  = d;
      r.length = len;
      r.err    = e;
      expected_q.push_back(r);
    endfunction

    // every error returns the decoder to waiting for a quote
    function void push_error(logic [2:0] e);
      phase = PH_IDLE;
      push_result(K_ERR, 8'd0, 16'd0, e);
    endfunction

    // one decoded byte; the last buffer slot is kept for the terminator
    function void store_char(logic [7:0] c);
      if (c == 8'd0) begin
        push_error(E_NUL);
      end else if ({1'b0, count} + 17'd1 >= {1'b0, capacity}) begin
        push_error(E_FULL);
      end else begin
        count = count + 16'd1;
        phase = PH_STR;
        push_result(K_BYTE, c, 16'd0, E_NONE);
      end
    endfunction

    function void note_word(logic [7:0] b, logic last);
      if (phase == PH_IDLE) begin
        if (last || b != CHR_QUOTE) begin
          push_error(E_NOQUOTE);
        end else begin
          count = '0;
          phase = PH_STR;
        end
      end else if (last) begin
        push_error(E_UNTERM);
      end else if (phase == PH_ESC) begin
        case (b)
          CHR_QUOTE, CHR_BSLASH, CHR_SLASH: store_char(b);
          "b":     store_char(8'd8);
          "f":     store_char(8'd12);
          "n":     store_char(8'd10);
          "r":     store_char(8'd13);
          "t":     store_char(8'd9);
          default: push_error(E_ESC);
        endcase
      end else if (b == CHR_QUOTE) begin
        // closing quote; overflows only when count is not below capacity
        phase = PH_IDLE;
        if (count >= capacity) push_result(K_ERR, 8'd0, 16'd0, E_FULL);
        else push_result(K_DONE, 8'd0, count, E_NONE);
      end else if (b < CTRL_LIMIT) begin
        push_error(E_CTRL);
      end else if (b == CHR_BSLASH) begin
        phase = PH_ESC;
      end else begin
        store_char(b);
      end
    endfunction

    // fields shown as kind/byte/len/err
    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: exp %0d/%02h/%0d/%0d, got %0d/%02h/%0d/%0d",
                 $time, what, want.kind, want.dbyte, want.length, want.err,
                 got.kind, got.dbyte, got.length, got.err);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.dbyte !== want.dbyte ||
          got.length !== want.length || got.err !== want.err)
        report("mismatch", want, got);
    endfunction
  endclass

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } line_word_t;

  unescape_scoreboard sb;
  line_word_t         stim_q[$];
  int                 hold_left   = 0;
  int                 stall_left  = 0;
  bit                 tx_quiet    = 1'b0;
  bit                 rx_quiet    = 1'b0;
  int                 idle_cycles = 0;

  // Result monitor
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = kind_t'(out_tuser);
      got.dbyte  = out_tdata[7:0];
      got.length = out_tdata[23:8];
      got.err    = out_tdata[26:24];
      sb.check_word(got);
    end
  end

  // Receiver back-pressure: random stalls, quiet stretches, one forced long hold
  initial begin
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
        out_tready = 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) - 1
                                                 : $urandom_range(1, 3) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_tx_gap();
    int r;
    if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
    if (tx_quiet || hold_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 255));
    while (c == CHR_QUOTE || c == CHR_BSLASH);
    return c;
  endfunction

  task automatic push_byte(logic [7:0] b);
    stim_q.push_back('{b, 1'b0});
  endtask

  // line end carries random data, which the block ignores
  task automatic push_line_end();
    stim_q.push_back('{8'($urandom), 1'b1});
  endtask

  task automatic push_char();
    if ($urandom_range(0, 4) == 0) begin
      push_byte(CHR_BSLASH);
      push_byte(ESC_LETTERS[$urandom_range(0, 7)]);
    end else begin
      push_byte(plain_char());
    end
  endtask

  // One line: mostly a well-formed string, else a broken one or raw noise
  task automatic gen_line();
    int sel;
    int len;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 7) == 0) push_line_end();
        else push_byte(8'($urandom_range(0, 255)));
      end
      return;
    end
    push_byte(CHR_QUOTE);
    if (sel >= 78) len = $urandom_range(0, 4);
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 70);
    else len = $urandom_range(0, 8);
    repeat (len) push_char();
    if (sel < 78) begin
      push_byte(CHR_QUOTE);
      if ($urandom_range(0, 3) == 0) push_line_end();
    end else begin
      case ($urandom_range(0, 4))
        0: push_byte(8'($urandom_range(0, 31)));
        1: push_line_end();
        2: begin
          push_byte(CHR_BSLASH);
          push_line_end();
        end
        3: begin
          push_byte(CHR_BSLASH);
          push_byte(8'($urandom_range(0, 255)));
        end
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Drive queued words; valid stays up across back-to-back words
  task automatic send_all();
    line_word_t w;
    int         gap;
    while (stim_q.size() != 0) begin
      w = stim_q.pop_front();
      @(negedge clk);
      in_tvalid = 1'b1;
      in_tdata  = w.b;
      in_tlast  = w.last;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      sb.note_word(w.b, w.last);
      gap = pick_tx_gap();
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic run_random(int n);
    while (stim_q.size() < n) gen_line();
    send_all();
  endtask

  // Quote or backslash words leave nothing behind, so allow a few extra cycles
  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] v);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CAP_ADDR;
    cfg_pwdata  = {16'd0, v};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_capacity(v);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: byte extremes, every escape, and the no-quote, control, unterminated and bad-escape errors
    push_line_end();
    push_byte(CHR_QUOTE);
    push_byte(8'hff);
    push_byte(8'h20);
    for (int i = 0; i < 8; i++) begin
      push_byte(CHR_BSLASH);
      push_byte(ESC_LETTERS[i]);
    end
    push_byte(8'h1f);
    push_byte(CHR_QUOTE);
    push_byte(CHR_BSLASH);
    push_line_end();
    push_byte(CHR_QUOTE);
    push_byte(CHR_BSLASH);
    push_byte(8'h01);
    send_all();

    // Reset capacity; sender pauses to empty, then a long receiver hold
    run_random(300);
    wait_drained();
    hold_left = 120;
    run_random(300);
    wait_drained();

    // Zero capacity: even the empty string overflows
    write_capacity(16'd0);
    push_byte(CHR_QUOTE);
    push_byte(CHR_QUOTE);
    push_byte(CHR_QUOTE);
    push_byte("a");
    run_random(100);
    wait_drained();

    // Capacity one: only the empty string fits
    write_capacity(16'd1);
    push_byte(CHR_QUOTE);
    push_byte(CHR_QUOTE);
    run_random(150);
    wait_drained();

    write_capacity(16'd2);
    push_byte(CHR_QUOTE);
    push_byte("a");
    push_byte("b");
    run_random(200);
    wait_drained();

    write_capacity(16'hffff);
    run_random(400);
    wait_drained();

    write_capacity(16'd20);
    run_random(500);
    wait_drained();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
